// ----- rtl/lmd_pkg.sv -----
package lmd_pkg;

	// Geometry and pixel format
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIXEL_BITS = 16;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Configuration registers
	localparam int FW_W    = 11;
	localparam int FH_W    = 13;
	localparam int PEAK_W  = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int FW_RESET   = 640;
	localparam int FH_RESET   = 480;
	localparam int PEAK_RESET = 40;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_MIN_PEAK     = 2'd2
	} reg_idx_t;

	// Result fields
	localparam int PCOL_W     = 10;
	localparam int PROW_W     = 12;
	localparam int TOTAL_W    = 22;
	localparam int OUT_BITS   = PCOL_W + PROW_W + TOTAL_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_DATA_W  = ((PIXEL_BITS + 7) / 8) * 8;

	localparam logic RECORD_POINT = 1'b0;
	localparam logic RECORD_END   = 1'b1;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	// One new window column: two stored lines and the incoming pixel
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} lmd_col_t;

endpackage

// ----- rtl/lmd_line_mem.sv -----
module lmd_line_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [lmd_pkg::COL_W-1:0] rd_addr,
	input  lmd_pkg::pix_t             pix,
	output lmd_pkg::lmd_col_t         col
);

	// Each entry holds {upper line, middle line} for one column
	logic [2*lmd_pkg::PIXEL_BITS-1:0] mem [lmd_pkg::MAX_WIDTH];
	logic [2*lmd_pkg::PIXEL_BITS-1:0] rdata_q;
	logic [lmd_pkg::COL_W-1:0]        addr_q;
	lmd_pkg::pix_t                    pix_q;
	logic                             wr_pend_q;

	// Read on accept, hold the read data until the next accept
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			addr_q  <= rd_addr;
			pix_q   <= pix;
		end
		if (wr_pend_q) begin
			mem[addr_q] <= {rdata_q[lmd_pkg::PIXEL_BITS-1:0], pix_q};
		end
	end

	// Write back in the cycle after the read: middle moves up, pixel becomes middle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= rd_en;
		end
	end

	assign col.top = rdata_q[2*lmd_pkg::PIXEL_BITS-1:lmd_pkg::PIXEL_BITS];
	assign col.mid = rdata_q[lmd_pkg::PIXEL_BITS-1:0];
	assign col.bot = pix_q;

`ifndef SYNTHESIS
	a_no_raw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q && rd_en |-> rd_addr != addr_q)
		else $error("line store read overlaps pending write of same column");
`endif

endmodule

// ----- rtl/lmd_window.sv -----
module lmd_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  lmd_pkg::lmd_col_t          col,
	input  logic [lmd_pkg::PEAK_W-1:0] min_peak,
	output logic                       peak
);

	lmd_pkg::pix_t win_q [9];
	lmd_pkg::pix_t nxt [9];
	logic [8:0]    ge;

	// Shift the window left and bring in the new column
	always_comb begin
		nxt[0] = win_q[1];
		nxt[1] = win_q[2];
		nxt[2] = col.top;
		nxt[3] = win_q[4];
		nxt[4] = win_q[5];
		nxt[5] = col.mid;
		nxt[6] = win_q[7];
		nxt[7] = win_q[8];
		nxt[8] = col.bot;
	end

	// Centre must be at least every neighbor and the threshold
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			ge[k] = nxt[4] >= nxt[k];
		end
	end

	assign peak = (&ge) && (32'(nxt[4]) >= 32'(min_peak));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (adv) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= nxt[k];
			end
		end
	end

endmodule

// ----- rtl/local_maximum_3x3_detector.sv -----
// 3x3 local-maximum detector over a raster-order pixel stream.
// Input channel s_*: one pixel per item, row by row, frame_width items per row,
// frame_height rows per frame. Output channel m_*: result items. A point record
// (m_tuser = 0) carries the column and row of an interior pixel that is at least
// each of its eight neighbors and at least min_peak_value; it leaves once the
// pixel one row and one column below it has been taken. After the last pixel
// of a frame an end record (m_tuser = 1, m_tlast = 1) carries the point count.
// Throughput: one pixel per cycle while results drain. Two results from the last
// pixel of a frame both occupy the output register until taken. The line store
// read is registered when a pixel is accepted, and the window compare into the
// output register when stage 1 advances. The two line buffers share one memory
// (1024 x 32 bits), read at the column on accept and written back the following
// cycle. The user must make configuration writes (cfg_we) only while the block
// is idle; the block does not check this. A write of frame width or height
// restarts the frame. Reset restores the default geometry (640 x 480) and
// threshold (40) and empties the pipeline; line contents need no clearing. When
// m_tready is low, results wait in the output register and one more pixel is
// taken before s_tready drops.
module local_maximum_3x3_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lmd_pkg::IN_DATA_W-1:0]  s_tdata,  // [15:0] pixel_value
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [9:0] point_col, [21:10] point_row, [43:22] point_total, rest zero
	output logic [lmd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tuser,  // [0] record_kind
	output logic                           m_tlast,  // frame_last
	input  logic                           cfg_we,
	input  logic [lmd_pkg::IDX_W-1:0]      cfg_index,
	input  logic [lmd_pkg::CFG_W-1:0]      cfg_data
);

	logic [lmd_pkg::FW_W-1:0]    frame_width_q;
	logic [lmd_pkg::FH_W-1:0]    frame_height_q;
	logic [lmd_pkg::PEAK_W-1:0]  min_peak_q;
	logic                        restart;

	logic [lmd_pkg::COL_W-1:0]   col_q;
	logic [lmd_pkg::ROW_W-1:0]   row_q;
	logic [lmd_pkg::TOTAL_W-1:0] found_q;
	logic [lmd_pkg::COL_W-1:0]   w_last;
	logic [lmd_pkg::ROW_W-1:0]   h_last;
	logic                        eol;
	logic                        eof;
	logic                        s_fire;

	logic                        valid_s1;
	logic [lmd_pkg::COL_W-1:0]   col_s1;
	logic [lmd_pkg::ROW_W-1:0]   row_s1;
	logic                        inner_s1;
	logic                        eof_s1;

	lmd_pkg::lmd_col_t           lcol;
	logic                        peak;
	logic                        adv;
	logic                        hit;
	logic [lmd_pkg::TOTAL_W-1:0] found_nxt;

	logic                        pt_pend_q;
	logic                        end_pend_q;
	logic [lmd_pkg::PCOL_W-1:0]  out_col_q;
	logic [lmd_pkg::PROW_W-1:0]  out_row_q;
	logic [lmd_pkg::TOTAL_W-1:0] out_total_q;
	logic                        out_free;
	logic                        m_fire;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= lmd_pkg::FW_W'(lmd_pkg::FW_RESET);
			frame_height_q <= lmd_pkg::FH_W'(lmd_pkg::FH_RESET);
			min_peak_q     <= lmd_pkg::PEAK_W'(lmd_pkg::PEAK_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				lmd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[lmd_pkg::FW_W-1:0];
				lmd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[lmd_pkg::FH_W-1:0];
				lmd_pkg::REG_MIN_PEAK:     min_peak_q     <= cfg_data[lmd_pkg::PEAK_W-1:0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index == lmd_pkg::REG_FRAME_WIDTH ||
		cfg_index == lmd_pkg::REG_FRAME_HEIGHT);

	// Saturate geometry to 3..max and take the last column and row index
	always_comb begin
		if (frame_width_q < lmd_pkg::FW_W'(3)) begin
			w_last = lmd_pkg::COL_W'(2);
		end else if (32'(frame_width_q) > 32'(lmd_pkg::MAX_WIDTH)) begin
			w_last = lmd_pkg::COL_W'(lmd_pkg::MAX_WIDTH - 1);
		end else begin
			w_last = lmd_pkg::COL_W'(frame_width_q - lmd_pkg::FW_W'(1));
		end
	end

	always_comb begin
		if (frame_height_q < lmd_pkg::FH_W'(3)) begin
			h_last = lmd_pkg::ROW_W'(2);
		end else if (32'(frame_height_q) > 32'(lmd_pkg::MAX_HEIGHT)) begin
			h_last = lmd_pkg::ROW_W'(lmd_pkg::MAX_HEIGHT - 1);
		end else begin
			h_last = lmd_pkg::ROW_W'(frame_height_q - lmd_pkg::FH_W'(1));
		end
	end

	assign eol    = col_q == w_last;
	assign eof    = eol && (row_q == h_last);
	assign s_fire = s_tvalid && s_tready;

	// Raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_fire) begin
			if (eol) begin
				col_q <= '0;
				row_q <= eof ? '0 : row_q + lmd_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + lmd_pkg::COL_W'(1);
			end
		end
	end

	lmd_line_mem u_line_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_fire),
		.rd_addr (col_q),
		.pix     (s_tdata[lmd_pkg::PIXEL_BITS-1:0]),
		.col     (lcol)
	);

	// Stage 1: line data arrives, window shifts and the centre is tested
	assign out_free = !(pt_pend_q || end_pend_q) || (m_tready && !(pt_pend_q && end_pend_q));
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			col_s1   <= col_q;
			row_s1   <= row_q;
			inner_s1 <= (col_q >= lmd_pkg::COL_W'(2)) && (row_q >= lmd_pkg::ROW_W'(2));
			eof_s1   <= eof;
		end
	end

	lmd_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.col      (lcol),
		.min_peak (min_peak_q),
		.peak     (peak)
	);

	// Count points, holding at the field maximum
	assign hit       = inner_s1 && peak;
	assign found_nxt = (hit && !(&found_q)) ? found_q + lmd_pkg::TOTAL_W'(1) : found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (restart) begin
			found_q <= '0;
		end else if (adv) begin
			found_q <= eof_s1 ? '0 : found_nxt;
		end
	end

	// Output register: point first, then the end record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_pend_q  <= 1'b0;
			end_pend_q <= 1'b0;
		end else if (adv) begin
			pt_pend_q  <= hit;
			end_pend_q <= eof_s1;
		end else if (m_fire) begin
			if (pt_pend_q) begin
				pt_pend_q <= 1'b0;
			end else begin
				end_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_col_q   <= lmd_pkg::PCOL_W'(col_s1 - lmd_pkg::COL_W'(1));
			out_row_q   <= lmd_pkg::PROW_W'(row_s1 - lmd_pkg::ROW_W'(1));
			out_total_q <= found_nxt;
		end
	end

	assign m_fire   = m_tvalid && m_tready;
	assign m_tvalid = pt_pend_q || end_pend_q;
	assign m_tuser  = pt_pend_q ? lmd_pkg::RECORD_POINT : lmd_pkg::RECORD_END;
	assign m_tlast  = !pt_pend_q;

	always_comb begin
		m_tdata = '0;
		if (pt_pend_q) begin
			m_tdata[lmd_pkg::PCOL_W-1:0] = out_col_q;
			m_tdata[lmd_pkg::PCOL_W +: lmd_pkg::PROW_W] = out_row_q;
		end else begin
			m_tdata[lmd_pkg::PCOL_W + lmd_pkg::PROW_W +: lmd_pkg::TOTAL_W] = out_total_q;
		end
	end

`ifndef SYNTHESIS
	a_ready_only_blocked_by_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with an empty stage 1");

	a_point_is_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lmd_pkg::RECORD_POINT |->
		out_col_q != '0 && out_row_q != '0)
		else $error("point record on a border pixel");

	a_frame_end_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && eof && !restart |=> col_q == '0 && row_q == '0)
		else $error("position not rewound after last pixel of frame");

	a_count_cleared_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eof_s1 |=> found_q == '0)
		else $error("point count not cleared at end of frame");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	// Register index that the block does not decode
	localparam logic [lmd_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned TOTAL_SAT = (1 << lmd_pkg::TOTAL_W) - 1;

	typedef struct packed {
		logic                        kind;
		logic [lmd_pkg::PCOL_W-1:0]  col;
		logic [lmd_pkg::PROW_W-1:0]  row;
		logic [lmd_pkg::TOTAL_W-1:0] total;
		logic                        last;
	} peak_rec_t;

	// Tracks the detector's window and counters, queues the records it should emit
	class lmd_peak_checker;
		logic [lmd_pkg::FW_W-1:0]   cfg_width;
		logic [lmd_pkg::FH_W-1:0]   cfg_height;
		lmd_pkg::pix_t              min_peak;
		lmd_pkg::pix_t              upper[lmd_pkg::MAX_WIDTH];
		lmd_pkg::pix_t              middle[lmd_pkg::MAX_WIDTH];
		lmd_pkg::pix_t              win[9];
		logic [lmd_pkg::COL_W-1:0]  col_pos;
		logic [lmd_pkg::ROW_W-1:0]  row_pos;
		logic [lmd_pkg::TOTAL_W:0]  found;
		peak_rec_t                  pending_peaks[$];
		int                         errors;

		function new();
			cfg_width  = lmd_pkg::FW_W'(lmd_pkg::FW_RESET);
			cfg_height = lmd_pkg::FH_W'(lmd_pkg::FH_RESET);
			min_peak   = lmd_pkg::pix_t'(lmd_pkg::PEAK_RESET);
			foreach (upper[i]) begin
				upper[i]  = '0;
				middle[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col_pos = '0;
			row_pos = '0;
			found   = '0;
			errors  = 0;
		endfunction

		function int eff_width();
			if (cfg_width < 3) return 3;
			if (cfg_width > lmd_pkg::MAX_WIDTH) return lmd_pkg::MAX_WIDTH;
			return int'(cfg_width);
		endfunction

		function int eff_height();
			if (cfg_height < 3) return 3;
			if (cfg_height > lmd_pkg::MAX_HEIGHT) return lmd_pkg::MAX_HEIGHT;
			return int'(cfg_height);
		endfunction

		// Items still needed to close the current frame
		function int frame_left();
			int w;
			int h;
			int c;
			int r;
			w = eff_width();
			h = eff_height();
			c = (col_pos >= w) ? 0 : int'(col_pos);
			r = (row_pos >= h) ? 0 : int'(row_pos);
			return w * h - (r * w + c);
		endfunction

		function int pending();
			return pending_peaks.size();
		endfunction

		// Geometry writes restart the frame; unknown indexes are dropped
		function void take_reg(logic [lmd_pkg::IDX_W-1:0] idx, logic [lmd_pkg::CFG_W-1:0] data);
			case (idx)
				lmd_pkg::REG_FRAME_WIDTH: begin
					cfg_width = data[lmd_pkg::FW_W-1:0];
					col_pos = '0;
					row_pos = '0;
					found   = '0;
				end
				lmd_pkg::REG_FRAME_HEIGHT: begin
					cfg_height = data[lmd_pkg::FH_W-1:0];
					col_pos = '0;
					row_pos = '0;
					found   = '0;
				end
				lmd_pkg::REG_MIN_PEAK: min_peak = data[lmd_pkg::PEAK_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pixel(lmd_pkg::pix_t pix);
			int w;
			int h;
			int c;
			int r;
			lmd_pkg::pix_t top;
			lmd_pkg::pix_t mid;
			logic hit;
			peak_rec_t rec;
			w = eff_width();
			h = eff_height();
			if (col_pos >= w) col_pos = '0;
			if (row_pos >= h) row_pos = '0;
			c = int'(col_pos);
			r = int'(row_pos);
			top = upper[c];
			mid = middle[c];
			// Shift the window left, bring in the new column
			for (int k = 0; k < 3; k++) begin
				win[k*3]   = win[k*3+1];
				win[k*3+1] = win[k*3+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = pix;
			upper[c]  = mid;
			middle[c] = pix;
			// Centre must be at least every neighbor and the threshold
			if (r >= 2 && c >= 2) begin
				hit = (win[4] >= min_peak);
				for (int k = 0; k < 9; k++)
					if (k != 4 && win[4] < win[k]) hit = 1'b0;
				if (hit) begin
					rec.kind  = lmd_pkg::RECORD_POINT;
					rec.col   = lmd_pkg::PCOL_W'(c - 1);
					rec.row   = lmd_pkg::PROW_W'(r - 1);
					rec.total = '0;
					rec.last  = 1'b0;
					pending_peaks.push_back(rec);
					if (found < TOTAL_SAT) found = found + 1'b1;
				end
			end
			// Advance position; close the frame on its last pixel
			if (c + 1 >= w) begin
				col_pos = '0;
				if (r + 1 >= h) begin
					rec.kind  = lmd_pkg::RECORD_END;
					rec.col   = '0;
					rec.row   = '0;
					rec.total = found[lmd_pkg::TOTAL_W-1:0];
					rec.last  = 1'b1;
					pending_peaks.push_back(rec);
					row_pos = '0;
					found   = '0;
				end else begin
					row_pos = lmd_pkg::ROW_W'(r + 1);
				end
			end else begin
				col_pos = lmd_pkg::COL_W'(c + 1);
			end
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_record(logic kind, logic [lmd_pkg::PCOL_W-1:0] col,
				logic [lmd_pkg::PROW_W-1:0] row,
				logic [lmd_pkg::TOTAL_W-1:0] total, logic last);
			peak_rec_t want;
			if (pending_peaks.size() == 0) begin
				report($sformatf("unexpected record kind %0b col %0d row %0d total %0d last %0b",
					kind, col, row, total, last));
				return;
			end
			want = pending_peaks.pop_front();
			if (kind !== want.kind || col !== want.col || row !== want.row ||
					total !== want.total || last !== want.last)
				report($sformatf({"got kind %0b col %0d row %0d total %0d last %0b, ",
					"want %0b %0d %0d %0d %0b"},
					kind, col, row, total, last,
					want.kind, want.col, want.row, want.total, want.last));
		endtask
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [lmd_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [lmd_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tuser;
	logic                           m_tlast;
	logic                           cfg_we    = 1'b0;
	logic [lmd_pkg::IDX_W-1:0]      cfg_index = '0;
	logic [lmd_pkg::CFG_W-1:0]      cfg_data  = '0;

	lmd_peak_checker sb;
	int  burst_left = 0;
	bit  gaps_on    = 1'b1;
	bit  hold_req   = 1'b0;
	int  hold_left  = 0;
	int  rx_mode    = 0;
	int  rx_left    = 0;
	int  rand_items = 0;

	local_maximum_3x3_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sample handshakes and register writes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_record(m_tuser, m_tdata[lmd_pkg::PCOL_W-1:0],
					m_tdata[lmd_pkg::PCOL_W+lmd_pkg::PROW_W-1:lmd_pkg::PCOL_W],
					m_tdata[lmd_pkg::PCOL_W+lmd_pkg::PROW_W+lmd_pkg::TOTAL_W-1:
						lmd_pkg::PCOL_W+lmd_pkg::PROW_W], m_tlast);
			if (s_tvalid && s_tready)
				sb.take_pixel(s_tdata[lmd_pkg::PIXEL_BITS-1:0]);
			if (cfg_we)
				sb.take_reg(cfg_index, cfg_data);
		end
	end

	// Receiver: long hold-off on request, otherwise a changing stall pattern
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((rx_left % 5) != 0);
			endcase
		end
	end

	task automatic write_reg(input logic [lmd_pkg::IDX_W-1:0] idx, input int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[lmd_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one pixel, with bursts and gaps, and hold it until taken
	task automatic push_pixel(input lmd_pkg::pix_t value);
		int gap;
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic lmd_pkg::pix_t draw_pixel(int mode, lmd_pkg::pix_t base);
		case (mode)
			0: return lmd_pkg::pix_t'($urandom_range(0, 65535));
			1: return lmd_pkg::pix_t'($urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return lmd_pkg::pix_t'(base + $urandom_range(0, 2) - 1);
		endcase
	endfunction

	task automatic send_run(input int n, input int mode, input lmd_pkg::pix_t base);
		for (int i = 0; i < n; i++) push_pixel(draw_pixel(mode, base));
	endtask

	// Drop valid, let every expected record arrive, then cover the pipeline
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		int sel;
		int mode;
		int n;
		int left;
		int thr;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Undersized geometry saturates to 3x3; lone bright centre at reset threshold
		write_reg(lmd_pkg::REG_FRAME_WIDTH, 0);
		write_reg(lmd_pkg::REG_FRAME_HEIGHT, 2);
		for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 16'hFFFF : 16'h0000);
		wait_idle();

		// Tied plateau exactly at the top threshold
		write_reg(lmd_pkg::REG_FRAME_WIDTH, 4);
		write_reg(lmd_pkg::REG_FRAME_HEIGHT, 3);
		write_reg(lmd_pkg::REG_MIN_PEAK, 16'hFFFF);
		for (int i = 0; i < 12; i++) push_pixel((i == 5 || i == 6) ? 16'hFFFF : 16'h0000);
		wait_idle();

		// Part of a frame, then restart it with a geometry write
		write_reg(lmd_pkg::REG_MIN_PEAK, lmd_pkg::PEAK_RESET);
		for (int i = 0; i < 4; i++) push_pixel(lmd_pkg::pix_t'($urandom_range(0, 65535)));
		wait_idle();
		write_reg(lmd_pkg::REG_FRAME_WIDTH, 3);
		write_reg(REG_SPARE, 16'hFFFF);

		// Oversized geometry saturated to the widest row, left unfinished past one row
		write_reg(lmd_pkg::REG_FRAME_WIDTH, 2047);
		write_reg(lmd_pkg::REG_FRAME_HEIGHT, 8191);
		write_reg(lmd_pkg::REG_MIN_PEAK, 0);
		send_run(lmd_pkg::MAX_WIDTH + 16, 0, '0);
		wait_idle();

		// Flat frame: every interior pixel is a point while the receiver holds off
		write_reg(lmd_pkg::REG_FRAME_WIDTH, 16);
		write_reg(lmd_pkg::REG_FRAME_HEIGHT, 16);
		gaps_on  = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 256; i++) push_pixel(16'h1234);
		gaps_on = 1'b1;
		wait_idle();

		// Random phases: mostly whole frames, some cut short
		while (rand_items < 250) begin
			wait_idle();
			if ($urandom_range(0, 9) < 7) begin
				sel = $urandom_range(0, 19);
				write_reg(lmd_pkg::REG_FRAME_WIDTH, (sel == 0) ? $urandom_range(0, 2) :
					(sel < 4) ? $urandom_range(11, 32) : $urandom_range(3, 10));
			end
			if ($urandom_range(0, 9) < 7) begin
				sel = $urandom_range(0, 19);
				write_reg(lmd_pkg::REG_FRAME_HEIGHT, (sel == 0) ? $urandom_range(0, 2) :
					(sel < 4) ? $urandom_range(7, 12) : $urandom_range(3, 6));
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 3))
					0: thr = 0;
					1: thr = $urandom_range(0, 65535);
					2: thr = $urandom_range(0, 8);
					default: thr = 65535;
				endcase
				write_reg(lmd_pkg::REG_MIN_PEAK, thr);
			end
			if ($urandom_range(0, 19) == 0)
				write_reg(REG_SPARE, $urandom_range(0, 65535));
			mode = $urandom_range(0, 3);
			left = sb.frame_left();
			if ($urandom_range(0, 4) != 0)
				n = left + $urandom_range(0, 1) * sb.eff_width() * sb.eff_height();
			else
				n = $urandom_range(1, left);
			send_run(n, mode, sb.min_peak);
			rand_items += n;
		end

		wait_idle();
		if (sb.errors == 0) begin
			$display("** local_maximum_3x3_detector: PASSED **");
		end else begin
			$display("** local_maximum_3x3_detector: FAILED **");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin : watchdog
		#25_000_000;
		$display("** local_maximum_3x3_detector: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lmd_pkg.sv
rtl/lmd_line_mem.sv
rtl/lmd_window.sv
rtl/local_maximum_3x3_detector.sv
dv/tb_top.sv
